### rtl/ilir_pkg.sv
// Shared types, codes and defaults for the indexed list block.
`default_nettype none
package ilir_pkg;

	localparam int CAPACITY_DEF      = 16;
	localparam int ELEMENT_WIDTH_DEF = 32;

	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int IN_W     = 32;
	localparam int STATUS_W = 2;
	localparam int OUT_W    = 32;
	localparam int LEN_W    = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_POP    = 3'd3,
		OP_GET    = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell of the row in the cycle a word is accepted.
	typedef struct packed {
		logic push;  // cell at index length takes the new element
		logic ins;   // cell at position takes the new element, later cells take left
		logic rem;   // cells at or above position take right
	} cell_ctl_t;

endpackage
`default_nettype wire

### rtl/ilir_cell.sv
// One storage cell of the list row with its shift, write and read-select logic.
`default_nettype none
module ilir_cell
	import ilir_pkg::*;
#(
	parameter int CW            = 5,
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
	parameter int IDX           = 0
) (
	input  wire logic                     clk,
	input  wire cell_ctl_t                ctl,
	input  wire logic [CW-1:0]            pos,
	input  wire logic [CW-1:0]            len,
	input  wire logic [CW-1:0]            rd_idx,
	input  wire logic [ELEMENT_WIDTH-1:0] new_val,
	input  wire logic [ELEMENT_WIDTH-1:0] left,
	input  wire logic [ELEMENT_WIDTH-1:0] right,
	output logic      [ELEMENT_WIDTH-1:0] data,
	output logic      [ELEMENT_WIDTH-1:0] rd_data
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [ELEMENT_WIDTH-1:0] data_q;

	// Cells above the end may pick up stale words; they are never read.
	always_ff @(posedge clk) begin
		if (ctl.push && MY_IDX == len) begin
			data_q <= new_val;
		end else if (ctl.ins && MY_IDX == pos) begin
			data_q <= new_val;
		end else if (ctl.ins && MY_IDX > pos) begin
			data_q <= left;
		end else if (ctl.rem && MY_IDX >= pos) begin
			data_q <= right;
		end
	end

	assign data    = data_q;
	assign rd_data = (MY_IDX == rd_idx) ? data_q : '0;

endmodule
`default_nettype wire

### rtl/ilir_ctrl.sv
// Operation decode: status, next length, read index and cell commands.
`default_nettype none
module ilir_ctrl
	import ilir_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CW       = 5
) (
	input  wire logic [OP_W-1:0]  operation,
	input  wire logic [CW-1:0]    pos,
	input  wire logic [CW-1:0]    len,
	input  wire logic             accept,
	output cell_ctl_t             ctl,
	output status_t               status,
	output logic      [CW-1:0]    len_next,
	output logic      [CW-1:0]    rd_idx,
	output logic                  rd_en
);

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	logic      full;
	logic      push_ok;
	logic      ins_ok;
	logic      rem_ok;
	op_t       op_eff;

	assign full = (len >= CAP_C);

	always_comb begin
		// Insert at the end behaves exactly as push.
		if (operation == OP_INSERT && pos == len) begin
			op_eff = OP_PUSH;
		end else begin
			op_eff = op_t'(operation);
		end

		status   = ST_OK;
		len_next = len;
		rd_idx   = pos;
		rd_en    = 1'b0;
		push_ok  = 1'b0;
		ins_ok   = 1'b0;
		rem_ok   = 1'b0;

		unique case (op_eff)
			OP_PUSH: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					push_ok  = 1'b1;
					len_next = len + ONE_C;
				end
			end
			OP_INSERT: begin
				if (pos > len) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					ins_ok   = 1'b1;
					len_next = len + ONE_C;
				end
			end
			OP_REMOVE: begin
				if (pos >= len) begin
					status = ST_RANGE;
				end else begin
					rem_ok   = 1'b1;
					rd_en    = 1'b1;
					len_next = len - ONE_C;
				end
			end
			OP_POP: begin
				rd_idx = len - ONE_C;
				if (len == '0) begin
					status = ST_RANGE;
				end else begin
					rd_en    = 1'b1;
					len_next = len - ONE_C;
				end
			end
			OP_GET: begin
				if (pos >= len) begin
					status = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_CLEAR: begin
				len_next = '0;
			end
			default: begin
				status = ST_RANGE;
			end
		endcase

		ctl.push = accept && push_ok;
		ctl.ins  = accept && ins_ok;
		ctl.rem  = accept && rem_ok;
	end

endmodule
`default_nettype wire

### rtl/indexed_list_insert_remove.sv
// Top level of the indexed list: decode, row of cells, length and output register.
//
// Usage: an ordered list of up to CAPACITY elements held in a row of cells.
// Input channel (in_valid, in_stall) carries operation, position and
// element_in; every accepted word gives exactly one result word on the
// output channel (out_valid, out_stall) with status, element_out and
// length_after. A word is accepted when valid is high and stall is low.
// The result is held in the output register from the cycle after the word
// is accepted. Throughput: one word per cycle while the output is not stalled;
// every cell shifts in the same cycle, so insert and remove cost no more
// than get. The decode and the read select across the row set the clock path.
// A result waiting under out_stall holds the output register; in_stall
// is raised only while that register is full and stalled, so the next
// word is taken in the same cycle the pending result leaves.
// Reset clears the length to zero and empties the output register. Cell
// contents are not reset; only entries below the length are ever read.
`default_nettype none
module indexed_list_insert_remove
	import ilir_pkg::*;
#(
	parameter int CAPACITY      = CAPACITY_DEF,
	parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic [IN_W-1:0]     element_in,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [STATUS_W-1:0] status,
	output logic      [OUT_W-1:0]    element_out,
	output logic      [LEN_W-1:0]    length_after
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;
	localparam int XW = 64;

	logic                     accept;
	logic [LW-1:0]            len_q;
	logic [CW-1:0]            len_c;
	logic [CW-1:0]            pos_c;
	logic [CW-1:0]            len_next;
	logic [CW-1:0]            rd_idx;
	logic                     rd_en;
	cell_ctl_t                ctl;
	status_t                  st;
	logic [XW-1:0]            in_x;
	logic [ELEMENT_WIDTH-1:0] new_val;
	logic [ELEMENT_WIDTH-1:0] data_w    [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rd_w      [CAPACITY];
	logic [ELEMENT_WIDTH-1:0] rd_sel;
	logic [XW-1:0]            rd_x;
	logic [XW-1:0]            len_x;

	logic                     out_valid_q;
	status_t                  status_q;
	logic [OUT_W-1:0]         elem_q;
	logic [LEN_W-1:0]         len_out_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		len_c              = '0;
		len_c[LW-1:0]      = len_q;
		pos_c              = '0;
		pos_c[POS_W-1:0]   = position;
		in_x               = '0;
		in_x[IN_W-1:0]     = element_in;
		new_val            = in_x[ELEMENT_WIDTH-1:0];
	end

	ilir_ctrl #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_ctrl (
		.operation (operation),
		.pos       (pos_c),
		.len       (len_c),
		.accept    (accept),
		.ctl       (ctl),
		.status    (st),
		.len_next  (len_next),
		.rd_idx    (rd_idx),
		.rd_en     (rd_en)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] left_w;
		logic [ELEMENT_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = data_w[i];
		end else begin : g_mid_r
			assign right_w = data_w[i+1];
		end

		ilir_cell #(
			.CW            (CW),
			.ELEMENT_WIDTH (ELEMENT_WIDTH),
			.IDX           (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.pos     (pos_c),
			.len     (len_c),
			.rd_idx  (rd_idx),
			.new_val (new_val),
			.left    (left_w),
			.right   (right_w),
			.data    (data_w[i]),
			.rd_data (rd_w[i])
		);
	end

	// Only the addressed cell drives a nonzero word, so an OR picks it out.
	always_comb begin
		rd_sel = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_sel = rd_sel | rd_w[k];
		end
		rd_x                    = '0;
		rd_x[ELEMENT_WIDTH-1:0] = rd_en ? rd_sel : '0;
		len_x                   = '0;
		len_x[CW-1:0]           = len_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				len_q <= len_next[LW-1:0];
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= st;
			elem_q    <= rd_x[OUT_W-1:0];
			len_out_q <= len_x[LEN_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign element_out  = elem_q;
	assign length_after = len_out_q;

	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	a_len_bound : assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP_L)
		else $error("length exceeds capacity");

	a_full_len : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_FULL |-> len_q == CAP_L)
		else $error("full status while list not full");

	a_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> elem_q == '0)
		else $error("element returned with error status");

	a_stall_src : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled with output register free");

	a_len_track : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> len_out_q == LEN_W'(len_q))
		else $error("reported length differs from held length");

endmodule
`default_nettype wire

### verif/indexed_list_insert_remove_checker.sv
// Checker for the indexed list: predicts every result word and compares it field by field.
`default_nettype none
module indexed_list_insert_remove_checker
	import ilir_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic [IN_W-1:0]     element_in,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire logic [STATUS_W-1:0] status,
	input  wire logic [OUT_W-1:0]    element_out,
	input  wire logic [LEN_W-1:0]    length_after,
	output int                       failures,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t          st;
		logic [OUT_W-1:0] elem;
		logic [LEN_W-1:0] len;
	} list_result_t;

	list_result_t     expected_results[$];
	list_result_t     oldest;
	list_result_t     predicted;
	logic [IN_W-1:0]  list_cells [CAPACITY_DEF];
	int               list_len;

	task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		failures++;
	endtask

	// Applies one word to the list copy and returns the result word it should give.
	task automatic apply_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic [IN_W-1:0] val, output list_result_t res);
		logic [OP_W-1:0] code;
		int at;
		int k;
		code = op;
		at = int'(pos);
		res.st = ST_OK;
		res.elem = '0;
		// Insert right behind the last element behaves as an append.
		if (code == OP_INSERT && at == list_len)
			code = OP_PUSH;
		case (code)
			OP_PUSH: begin
				if (list_len >= CAPACITY_DEF) begin
					res.st = ST_FULL;
				end else begin
					list_cells[list_len] = val;
					list_len++;
				end
			end
			OP_INSERT: begin
				if (at > list_len) begin
					res.st = ST_RANGE;
				end else if (list_len >= CAPACITY_DEF) begin
					res.st = ST_FULL;
				end else begin
					for (k = list_len; k > at; k--)
						list_cells[k] = list_cells[k-1];
					list_cells[at] = val;
					list_len++;
				end
			end
			OP_REMOVE: begin
				if (at >= list_len) begin
					res.st = ST_RANGE;
				end else begin
					res.elem = list_cells[at];
					for (k = at; k + 1 < list_len; k++)
						list_cells[k] = list_cells[k+1];
					list_len--;
				end
			end
			OP_POP: begin
				if (list_len == 0) begin
					res.st = ST_RANGE;
				end else begin
					list_len--;
					res.elem = list_cells[list_len];
				end
			end
			OP_GET: begin
				if (at >= list_len)
					res.st = ST_RANGE;
				else
					res.elem = list_cells[at];
			end
			OP_CLEAR: begin
				list_len = 0;
			end
			default: begin
				res.st = ST_RANGE;
			end
		endcase
		res.len = LEN_W'(list_len);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
			pending = 0;
			failures = 0;
		end else begin
			// The result leaving now belongs to an earlier word, so check before predicting.
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result word with nothing expected", element_out, '0);
				end else begin
					oldest = expected_results.pop_front();
					if (status !== oldest.st)
						report_mismatch("status", OUT_W'(status), OUT_W'(oldest.st));
					if (element_out !== oldest.elem)
						report_mismatch("element_out", element_out, oldest.elem);
					if (length_after !== oldest.len)
						report_mismatch("length_after", OUT_W'(length_after), OUT_W'(oldest.len));
				end
			end
			if (in_valid && !in_stall) begin
				apply_word(operation, position, element_in, predicted);
				expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule
`default_nettype wire

### verif/indexed_list_insert_remove_tb.sv
// Testbench top for the indexed list: clock, reset, word stimulus, output stalls and verdict.
`default_nettype none
module indexed_list_insert_remove_tb;
	import ilir_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;
	localparam int WORD_TOTAL  = 1024;
	localparam int PAUSE_AT    = 600;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation = OP_PUSH;
	logic [POS_W-1:0]    position = '0;
	logic [IN_W-1:0]     element_in = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [OUT_W-1:0]    element_out;
	logic [LEN_W-1:0]    length_after;

	int failures;
	int pending;
	int words_sent = 0;
	int burst_left = 0;
	int cycle_count = 0;

	indexed_list_insert_remove dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.position     (position),
		.element_in   (element_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.element_out  (element_out),
		.length_after (length_after)
	);

	indexed_list_insert_remove_checker list_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.position     (position),
		.element_in   (element_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.element_out  (element_out),
		.length_after (length_after),
		.failures     (failures),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("indexed_list_insert_remove_tb NOT OK");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge after the word was taken, after an idle gap when a burst ends.
	task automatic send_word(input logic [OP_W-1:0] op, input int pos,
			input logic [IN_W-1:0] val);
		in_valid <= 1'b1;
		operation <= op;
		position <= POS_W'(pos);
		element_in <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// Receiver: stall pattern of its own, plus one long hold-off while words keep coming.
	initial begin
		int kind;
		int n;
		bit held_off;
		held_off = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held_off && words_sent >= HOLD_AT) begin
				held_off = 1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
			end else begin
				kind = $urandom_range(0, 3);
				n = $urandom_range(4, 40);
				repeat (n) begin
					case (kind)
						0: out_stall <= 1'b0;
						1: out_stall <= $urandom_range(0, 1);
						2: out_stall <= ($urandom_range(0, 4) == 0);
						default: out_stall <= ($urandom_range(0, 9) < 8);
					endcase
					@(negedge clk);
				end
			end
		end
	end

	initial begin
		int mode;
		int run;
		int r;
		int pos;
		logic [OP_W-1:0] op;
		logic [IN_W-1:0] val;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words on a list whose length is tracked by hand.
		send_word(OP_CLEAR, 0, 32'h0);
		send_word(OP_POP, 0, 32'h0);
		send_word(OP_GET, 0, 32'h0);
		send_word(OP_REMOVE, 0, 32'h0);
		send_word(OP_INSERT, 1, 32'h1234_5678);
		send_word(OP_INSERT, 0, 32'hA5A5_A5A5);
		send_word(OP_PUSH, 0, 32'hFFFF_FFFF);
		send_word(OP_PUSH, 16, 32'h0000_0000);
		send_word(OP_INSERT, 1, 32'h5555_5555);
		send_word(OP_INSERT, 4, 32'hAAAA_AAAA);
		send_word(OP_INSERT, 0, 32'h0000_0001);
		send_word(OP_GET, 0, 32'h0);
		send_word(OP_GET, 5, 32'h0);
		send_word(OP_GET, 6, 32'h0);
		send_word(OP_GET, 16, 32'h0);
		send_word(OP_REMOVE, 1, 32'h0);
		send_word(OP_REMOVE, 4, 32'h0);
		send_word(OP_REMOVE, 4, 32'h0);
		send_word(OP_POP, 0, 32'h0);
		send_word(OP_UNUSED_A, 0, 32'hDEAD_BEEF);
		send_word(OP_UNUSED_B, 16, 32'hDEAD_BEEF);
		send_word(OP_CLEAR, 0, 32'h0);
		send_word(OP_POP, 0, 32'h0);
		wait_drained();

		// Random phases that lean toward filling, draining or a mix.
		while (words_sent < WORD_TOTAL) begin
			mode = $urandom_range(0, 2);
			run = $urandom_range(16, 64);
			repeat (run) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: op = (r < 45) ? OP_PUSH : (r < 80) ? OP_INSERT : (r < 90) ? OP_GET :
						(r < 96) ? OP_REMOVE : (r < 99) ? OP_POP : OP_CLEAR;
					1: op = (r < 10) ? OP_PUSH : (r < 20) ? OP_INSERT : (r < 35) ? OP_GET :
						(r < 70) ? OP_REMOVE : (r < 98) ? OP_POP : (r < 99) ? OP_CLEAR :
						OP_UNUSED_A;
					default: op = (r < 25) ? OP_PUSH : (r < 45) ? OP_INSERT :
						(r < 65) ? OP_GET : (r < 80) ? OP_REMOVE : (r < 95) ? OP_POP :
						(r < 97) ? OP_CLEAR : (r < 98) ? OP_UNUSED_A : OP_UNUSED_B;
				endcase
				r = $urandom_range(0, 9);
				if (r < 5)
					pos = $urandom_range(0, 3);
				else if (r < 8)
					pos = $urandom_range(0, 16);
				else
					pos = $urandom_range(10, 16);
				r = $urandom_range(0, 19);
				if (r == 0)
					val = '0;
				else if (r == 1)
					val = '1;
				else
					val = $urandom;
				send_word(op, pos, val);
				if (words_sent == PAUSE_AT)
					wait_drained();
			end
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("indexed_list_insert_remove_tb OK");
		else
			$display("indexed_list_insert_remove_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
